@@ hdl/m68k_subtract_group_alu_defines.svh @@
// Assertion macros used by the subtract group checker file.
`ifndef M68K_SUBTRACT_GROUP_ALU_DEFINES_SVH
`define M68K_SUBTRACT_GROUP_ALU_DEFINES_SVH

// Property checked on every clock edge, muted while reset is high.
`define M68SUB_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define M68SUB_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/m68sub_pkg.sv @@
// Types and constants for the 68000 subtract group execute block.
package m68sub_pkg;

   // operation size, opcode bits 7..6; the fourth code selects SUBA
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;
   localparam logic [1:0] SIZE_LONG = 2'd2;
   localparam logic [1:0] SIZE_ADDR = 2'd3;

   // effective address mode for address register direct
   localparam logic [2:0] MODE_AREG = 3'd1;

   typedef enum logic [1:0] {
      TGT_DREG = 2'd0,
      TGT_AREG = 2'd1,
      TGT_MEM  = 2'd2
   } target_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_ILLEGAL_BYTE = 2'd1,
      ST_SUBX_MEM     = 2'd2
   } status_type;

   typedef struct packed {
      logic x;
      logic n;
      logic z;
      logic v;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [31:0] value;
      target_type  target;
      logic [2:0]  tgt_reg;
      flags_type   flags;
      status_type  status;
   } exec_type;

endpackage

@@ hdl/m68sub_if.sv @@
// Valid/ready channel interfaces for the subtract group request and response items.
interface m68sub_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] opcode;
   logic [31:0] source_operand;
   logic [31:0] dest_operand;

   modport source (output valid, output opcode, output source_operand,
                   output dest_operand, input ready);
   modport sink (input valid, input opcode, input source_operand,
                 input dest_operand, output ready);
endinterface

interface m68sub_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic [1:0]  write_target;
   logic [2:0]  target_register;
   logic        flag_x;
   logic        flag_n;
   logic        flag_z;
   logic        flag_v;
   logic        flag_c;
   logic [1:0]  status;

   modport source (output valid, output result_value, output write_target,
                   output target_register, output flag_x, output flag_n,
                   output flag_z, output flag_v, output flag_c, output status,
                   input ready);
   modport sink (input valid, input result_value, input write_target,
                 input target_register, input flag_x, input flag_n,
                 input flag_z, input flag_v, input flag_c, input status,
                 output ready);
endinterface

@@ hdl/m68k_subtract_group_alu.sv @@
// Subtract group execute stage: SUB, SUBA and SUBX on fetched operands.
// Stages: the input register takes an accepted item, then its execute result loads the
// result register, where the item waits until it is taken.
// Throughput: one item per cycle unless the response stalls; the X/Z feedback is a single register loop.
// Reset (synchronous, active high) empties both stages and clears all flags.
module m68k_subtract_group_alu (
   input logic                 clock,
   input logic                 reset,
   m68sub_req_if.sink          req_port,
   m68sub_rsp_if.source        rsp_port
);

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [15:0]           s1_opcode_ff;
   logic [31:0]           s1_src_ff;
   logic [31:0]           s1_dst_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   m68sub_pkg::exec_type  rsp_data_ff;
   m68sub_pkg::flags_type flags_ff;
   m68sub_pkg::flags_type flags_in;
   m68sub_pkg::exec_type  exec;
   logic                  advance;
   logic                  load;
   logic                  retire;

   m68sub_alu u_alu (
      .opcode         (s1_opcode_ff),
      .source_operand (s1_src_ff),
      .dest_operand   (s1_dst_ff),
      .flags_in       (flags_ff),
      .result         (exec)
   );

   // the result register frees up when empty or when its item is taken
   assign advance = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = !s1_valid_ff || advance;
   assign load = req_port.valid && req_port.ready;
   assign retire = advance && s1_valid_ff;

   always_comb begin
      s1_valid_in  = req_port.ready ? req_port.valid : s1_valid_ff;
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      flags_in     = retire ? exec.flags : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_opcode_ff <= req_port.opcode;
         s1_src_ff    <= req_port.source_operand;
         s1_dst_ff    <= req_port.dest_operand;
      end
      if (retire) begin
         rsp_data_ff <= exec;
      end
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.result_value    = rsp_data_ff.value;
   assign rsp_port.write_target    = rsp_data_ff.target;
   assign rsp_port.target_register = rsp_data_ff.tgt_reg;
   assign rsp_port.flag_x          = rsp_data_ff.flags.x;
   assign rsp_port.flag_n          = rsp_data_ff.flags.n;
   assign rsp_port.flag_z          = rsp_data_ff.flags.z;
   assign rsp_port.flag_v          = rsp_data_ff.flags.v;
   assign rsp_port.flag_c          = rsp_data_ff.flags.c;
   assign rsp_port.status          = rsp_data_ff.status;

endmodule

@@ hdl/m68sub_alu.sv @@
// Opcode decode and sized subtract with 68000 flag rules.
module m68sub_alu (
   input  logic [15:0]           opcode,
   input  logic [31:0]           source_operand,
   input  logic [31:0]           dest_operand,
   input  m68sub_pkg::flags_type flags_in,
   output m68sub_pkg::exec_type  result
);

   logic [1:0]            size;
   logic [2:0]            mode;
   logic [2:0]            hreg;
   logic [2:0]            lreg;
   logic [31:0]           mask;
   logic [31:0]           msb;
   logic [31:0]           sm;
   logic [31:0]           dm;
   logic [31:0]           r;
   logic [31:0]           s_addr;
   logic [32:0]           diff;
   logic                  extended;
   logic                  xin;
   m68sub_pkg::flags_type fsub;

   always_comb begin
      size = opcode[7:6];
      mode = opcode[5:3];
      hreg = opcode[11:9];
      lreg = opcode[2:0];

      case (size)
         m68sub_pkg::SIZE_BYTE: begin
            mask = 32'h0000_00FF;
            msb  = 32'h0000_0080;
         end
         m68sub_pkg::SIZE_WORD: begin
            mask = 32'h0000_FFFF;
            msb  = 32'h0000_8000;
         end
         default: begin
            mask = 32'hFFFF_FFFF;
            msb  = 32'h8000_0000;
         end
      endcase

      sm = source_operand & mask;
      dm = dest_operand & mask;
      extended = opcode[8] && (opcode[5:4] == 2'b00);
      xin = extended & flags_in.x;
      // bit 32 of the difference is the borrow out of the operation size
      diff = {1'b0, dm} - {1'b0, sm} - {32'd0, xin};
      r = diff[31:0] & mask;

      fsub.x = diff[32];
      fsub.c = diff[32];
      fsub.n = |(r & msb);
      fsub.v = |((sm ^ dm) & (r ^ dm) & msb);
      // SUBX only ever clears Z
      fsub.z = extended ? (flags_in.z & ~(|r)) : ~(|r);

      s_addr = opcode[8] ? source_operand : {{16{source_operand[15]}}, source_operand[15:0]};

      result.value   = dest_operand;
      result.target  = m68sub_pkg::TGT_DREG;
      result.tgt_reg = hreg;
      result.flags   = flags_in;
      result.status  = m68sub_pkg::ST_OK;

      if (size == m68sub_pkg::SIZE_ADDR) begin
         result.value  = dest_operand - s_addr;
         result.target = m68sub_pkg::TGT_AREG;
      end else if (opcode[8]) begin
         if (opcode[5:4] == 2'b00) begin
            if (opcode[3]) begin
               result.status = m68sub_pkg::ST_SUBX_MEM;
            end else begin
               result.value = (dest_operand & ~mask) | r;
               result.flags = fsub;
            end
         end else begin
            result.value   = r;
            result.target  = m68sub_pkg::TGT_MEM;
            result.tgt_reg = lreg;
            result.flags   = fsub;
         end
      end else if (mode == m68sub_pkg::MODE_AREG && size == m68sub_pkg::SIZE_BYTE) begin
         result.status = m68sub_pkg::ST_ILLEGAL_BYTE;
      end else begin
         result.value = (dest_operand & ~mask) | r;
         result.flags = fsub;
      end
   end

endmodule

@@ hdl/m68sub_checker.sv @@
// Port-level checks for the subtract group execute block, bound to the top level.
`include "m68k_subtract_group_alu_defines.svh"

module m68sub_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_value,
   input logic [1:0]  rsp_write_target,
   input logic [1:0]  rsp_status,
   input logic        rsp_flag_x,
   input logic        rsp_flag_n,
   input logic        rsp_flag_z,
   input logic        rsp_flag_v,
   input logic        rsp_flag_c
);

   logic [4:0] cur_flags;
   logic [4:0] last_flags_ff;
   logic [4:0] last_flags_in;

   assign cur_flags = {rsp_flag_x, rsp_flag_n, rsp_flag_z, rsp_flag_v, rsp_flag_c};

   // flags as left by the last delivered item; cleared by reset like the block
   assign last_flags_in = (rsp_valid && rsp_ready) ? cur_flags : last_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_flags_ff <= '0;
      end else begin
         last_flags_ff <= last_flags_in;
      end
   end

   `M68SUB_ASSERT(a_reset_empty, clock, reset |=> !rsp_valid, "response valid right after reset")

   `M68SUB_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) && $stable(cur_flags) && $stable(rsp_status), "stalled response changed")

   `M68SUB_ASSERT_RST(a_reject_keeps_flags, clock, reset, rsp_valid && rsp_status != m68sub_pkg::ST_OK |-> rsp_write_target == m68sub_pkg::TGT_DREG && cur_flags == last_flags_ff, "rejected opcode touched flags or target")

   `M68SUB_ASSERT_RST(a_suba_keeps_flags, clock, reset, rsp_valid && rsp_write_target == m68sub_pkg::TGT_AREG |-> cur_flags == last_flags_ff && rsp_status == m68sub_pkg::ST_OK, "SUBA changed flags")

endmodule

bind m68k_subtract_group_alu m68sub_checker u_m68sub_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_result_value (rsp_port.result_value),
   .rsp_write_target (rsp_port.write_target),
   .rsp_status       (rsp_port.status),
   .rsp_flag_x       (rsp_port.flag_x),
   .rsp_flag_n       (rsp_port.flag_n),
   .rsp_flag_z       (rsp_port.flag_z),
   .rsp_flag_v       (rsp_port.flag_v),
   .rsp_flag_c       (rsp_port.flag_c)
);
